>>> rtl/pir_pkg.sv
`default_nettype none

package pir_pkg;

    // pixel and result widths
    localparam int PIX_W   = 8;
    localparam int RES_W   = 9;
    localparam int SUM_W   = 10;
    localparam int FW_W    = 11;
    localparam int FH_W    = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 1;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_A_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // floor(x/3) for x < 768 as (x * 683) >> 11
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_PW    = SUM_W + DIV3_SHIFT;

    // word held between the accept stage and the predictor stage
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             first_row;
        logic             first_col;
        logic             row_end;
        logic             frame_end;
    } pir_stage_t;

    function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] x);
        logic [DIV3_PW-1:0] prod;
        prod = DIV3_PW'(x) * DIV3_PW'(DIV3_MUL);
        return prod[DIV3_SHIFT +: PIX_W];
    endfunction

endpackage

`default_nettype wire

>>> rtl/pir_ram.sv
`default_nettype none

// simple dual-port RAM, one write port, one registered read port
module pir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire                     re,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/pixel_intra_residual.sv
// An accepted pixel passes the predictor stage and the output register.
// Throughput: one pixel per cycle unless m_ready stalls; the line store is
// read for a pixel at its accept and written when it leaves the predictor
// stage, with a bypass when both hit the same column (one-pixel rows).
// Reset (aresetn, synchronous, active low) clears counters, neighbor pixels and
// valid flags, and sets the frame to 1024 (at most MAX_WIDTH) by 1; the line
// store is not cleared.
`default_nettype none

module pixel_intra_residual
    import pir_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    // configuration
    input  wire                 cfg_wr_en,
    input  wire [CFG_A_W-1:0]   cfg_addr,
    input  wire [CFG_W-1:0]     cfg_wdata,
    // pixel input
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire [PIX_W-1:0]     s_pixel,
    // residual output
    output logic                m_valid,
    input  wire                 m_ready,
    output logic signed [RES_W-1:0] m_residual,
    output logic                m_row_end,
    output logic                m_frame_end
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int XW     = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int RST_FW = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    // frame geometry, kept as last column / last row
    logic [CW-1:0]   width_last_reg,  width_last_next;
    logic [FH_W-1:0] height_last_reg, height_last_next;

    // position of the next pixel to accept
    logic [CW-1:0]   col_reg,  col_next;
    logic [FH_W-1:0] row_reg,  row_next;

    // predictor stage
    logic             s1_valid_reg;
    pir_stage_t       s1_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             fwd_valid_reg;
    logic [PIX_W-1:0] fwd_data_reg;

    // causal neighbors
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] ul_reg;

    // output register
    logic                    m_valid_reg;
    logic signed [RES_W-1:0] m_residual_reg;
    logic                    m_row_end_reg;
    logic                    m_frame_end_reg;

    logic             accept;
    logic             s1_advance;
    logic             last_col;
    logic             last_row;
    logic [PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0] up;
    logic [SUM_W-1:0] sum3;
    logic [PIX_W-1:0] pred;
    logic [RES_W-1:0] residual;
    logic [FW_W-1:0]  cfg_fw;
    logic [FH_W-1:0]  cfg_fh;

    // handshake
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign accept     = s_valid && s_ready;

    // config decode: clamp width to 1..MAX_WIDTH, height to 1..
    assign cfg_fw = cfg_wdata[FW_W-1:0];
    assign cfg_fh = cfg_wdata[FH_W-1:0];

    always_comb begin
        width_last_next  = width_last_reg;
        height_last_next = height_last_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH: begin
                    if (cfg_fw == '0) begin
                        width_last_next = '0;
                    end else if (XW'(cfg_fw) > XW'(MAX_WIDTH)) begin
                        width_last_next = CW'(MAX_WIDTH - 1);
                    end else begin
                        width_last_next = CW'(XW'(cfg_fw) - XW'(1));
                    end
                end
                REG_FRAME_HEIGHT: begin
                    height_last_next = (cfg_fh == '0) ? '0 : cfg_fh - FH_W'(1);
                end
                default: begin
                    width_last_next = width_last_reg;
                end
            endcase
        end
    end

    // position flags and counter update
    assign last_col = (col_reg >= width_last_reg);
    assign last_row = last_col && (row_reg >= height_last_reg);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + FH_W'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_last_reg  <= CW'(RST_FW - 1);
            height_last_reg <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
        end else begin
            width_last_reg  <= width_last_next;
            height_last_reg <= height_last_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
        end
    end

    // line store: read at accept, written as the pixel leaves the predictor
    pir_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (s1_reg.pixel),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // predictor stage valid and bypass flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg  <= 1'b1;
                fwd_valid_reg <= s1_advance && (s1_col_reg == col_reg);
            end else if (s1_advance) begin
                s1_valid_reg  <= 1'b0;
            end
        end
    end

    // predictor stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg.pixel     <= s_pixel;
            s1_reg.first_row <= (row_reg == '0);
            s1_reg.first_col <= (col_reg == '0);
            s1_reg.row_end   <= last_col;
            s1_reg.frame_end <= last_row;
            s1_col_reg       <= col_reg;
            fwd_data_reg     <= s1_reg.pixel;
        end
    end

    // pred = div3(ul+up+left); div3(left) on row 0, div3(up) on col 0, 0 at (0,0)
    assign up   = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign sum3 = SUM_W'(ul_reg) + SUM_W'(up) + SUM_W'(left_reg);

    always_comb begin
        priority if (s1_reg.first_row && s1_reg.first_col) begin
            pred = '0;
        end else if (s1_reg.first_row) begin
            pred = div3(SUM_W'(left_reg));
        end else if (s1_reg.first_col) begin
            pred = div3(SUM_W'(up));
        end else begin
            pred = div3(sum3);
        end
    end

    assign residual = RES_W'(s1_reg.pixel) - RES_W'(pred);

    // neighbor registers follow the pixel leaving the predictor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            ul_reg   <= '0;
        end else if (s1_advance) begin
            left_reg <= s1_reg.pixel;
            ul_reg   <= up;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_residual_reg  <= signed'(residual);
            m_row_end_reg   <= s1_reg.row_end;
            m_frame_end_reg <= s1_reg.frame_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_residual  = m_residual_reg;
    assign m_row_end   = m_row_end_reg;
    assign m_frame_end = m_frame_end_reg;

    // checks
    a_frame_end_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_frame_end_reg |-> m_row_end_reg)
        else $error("frame end without row end");

    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !last_col |=> col_reg == $past(col_reg) + CW'(1))
        else $error("column counter did not step");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_ready)
        else $error("input stalled with empty predictor stage");

endmodule

`default_nettype wire
